### rtl/gdr_pkg.sv
package gdr_pkg;

  localparam int MapDim = 64;
  localparam int MapBits = 6;
  localparam int ScreenRows = 480;
  localparam int TexSize = 64;
  localparam int TexBits = 6;

  localparam logic [23:0] WdMax = 24'hFFFFFF;
  localparam logic [11:0] LhMax = 12'd4095;

  localparam logic [1:0] CfgPlayerX = 2'd0;
  localparam logic [1:0] CfgPlayerY = 2'd1;
  localparam logic [1:0] CfgMapWidth = 2'd2;
  localparam logic [1:0] CfgMapHeight = 2'd3;

  localparam logic ModeWrite = 1'b0;
  localparam logic ModeCast = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [5:0]         cell_x;
    logic [5:0]         cell_y;
    logic               cell_wall;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic [23:0]        delta_x;
    logic [23:0]        delta_y;
  } req_t;

  typedef struct packed {
    logic        status;
    logic        hit_side;
    logic [5:0]  hit_col;
    logic [5:0]  hit_row;
    logic [23:0] wall_distance;
    logic [11:0] slice_height;
    logic [8:0]  row_top;
    logic [8:0]  row_bottom;
    logic [5:0]  texture_col;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture request and set up side distances
    logic map_write; // write one map cell
    logic step;      // one DDA step, map read issued
    logic wd_start;  // start the distance division
    logic lh_start;  // start the height division
    logic tex_mul;   // texture product
    logic finish;    // form the result
  } cmd_t;

  typedef struct packed {
    logic is_write;
    logic outside;
    logic hit;
    logic div_done;
  } sts_t;

endpackage

### rtl/gdr_divider.sv
// Restoring divider, one quotient bit a cycle, 40-bit dividend.
module gdr_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [39:0] num,
  input  logic [23:0] den,
  output logic        done,
  output logic [39:0] quot
);
  import gdr_pkg::*;

  logic [39:0] q;
  logic [24:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [24:0] trial;

  assign trial = {rem[23:0], q[39]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 6'd0;
        q <= num;
        rem <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, den}) begin
          rem <= trial - {1'b0, den};
          q <= {q[38:0], 1'b1};
        end else begin
          rem <= trial;
          q <= {q[38:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd39) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = q;
endmodule

### rtl/gdr_datapath.sv
// Datapath: map memory, DDA registers, division and texture arithmetic.
module gdr_datapath (
  input  logic               clk,
  input  logic               rst,
  input  gdr_pkg::req_t      req,
  input  gdr_pkg::cmd_t      cmd,
  input  logic [15:0]        player_x,
  input  logic [15:0]        player_y,
  input  logic [6:0]         map_width,
  input  logic [6:0]         map_height,
  input  logic               clr_en,
  input  logic [11:0]        clr_addr,
  output gdr_pkg::sts_t      sts,
  output gdr_pkg::res_t      res
);
  import gdr_pkg::*;

  logic wall_map [MapDim*MapDim];
  logic map_rd;

  req_t        r;
  logic [31:0] sdx, sdy;
  logic [7:0]  mx, my;
  logic        side;
  logic [6:0]  w_lim, h_lim;
  logic [39:0] dv_num;
  logic [23:0] dv_den;
  logic        dv_done;
  logic [39:0] dv_q;
  logic [23:0] wd;
  logic [11:0] lh;
  logic        which; // 0 distance division, 1 height
  logic        div_h;
  logic signed [41:0] prod;
  logic [5:0]  tex;
  res_t        fin;

  // Setup values for the side distances.
  logic [9:0]  fx, fy;
  logic [10:0] kx, ky;
  logic [34:0] px, py;
  assign fx = player_x[9:0];
  assign fy = player_y[9:0];
  assign kx = req.dir_x[15] ? {1'b0, fx} : 11'd1024 - {1'b0, fx};
  assign ky = req.dir_y[15] ? {1'b0, fy} : 11'd1024 - {1'b0, fy};
  assign px = kx * req.delta_x;
  assign py = ky * req.delta_y;

  // Next cell after a step.
  logic        step_y;
  logic [7:0]  mx_n, my_n;
  assign step_y = !(sdx < sdy);
  assign mx_n = r.dir_x[15] ? mx - 8'd1 : mx + 8'd1;
  assign my_n = r.dir_y[15] ? my - 8'd1 : my + 8'd1;

  // Map write and read, plus the clearing pass after reset.
  always_ff @(posedge clk) begin
    if (clr_en) begin
      wall_map[clr_addr] <= 1'b0;
    end else if (cmd.map_write) begin
      wall_map[{req.cell_y, req.cell_x}] <= req.cell_wall;
    end
    map_rd <= wall_map[{my[5:0], mx[5:0]}];
  end

  // DDA registers. At most 64 steps are taken along each axis before the
  // ray leaves the map, so the side distances stay below 2^31.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r <= req;
      sdx <= {7'b0, px[34:10]};
      sdy <= {7'b0, py[34:10]};
      mx <= {2'b00, player_x[15:10]};
      my <= {2'b00, player_y[15:10]};
      w_lim <= (map_width > 7'(MapDim)) ? 7'(MapDim) : map_width;
      h_lim <= (map_height > 7'(MapDim)) ? 7'(MapDim) : map_height;
    end else if (cmd.step) begin
      if (step_y) begin
        sdy <= sdy + {8'b0, r.delta_y};
        my <= my_n;
        side <= 1'b1;
      end else begin
        sdx <= sdx + {8'b0, r.delta_x};
        mx <= mx_n;
        side <= 1'b0;
      end
    end
  end

  // A cell index that went below zero shows up as bit 7 set.
  assign sts.outside = mx[7] || my[7] || ({1'b0, mx} >= {2'b00, w_lim}) ||
                       ({1'b0, my} >= {2'b00, h_lim});
  assign sts.hit = map_rd;
  assign sts.is_write = (req.mode == ModeWrite);
  assign sts.div_done = dv_done;

  // Wall distance numerator and denominator.
  logic signed [17:0] nm;
  logic [16:0]        nabs;
  logic [15:0]        dabs;
  logic signed [15:0] dsel;
  always_comb begin
    if (side == 1'b0) begin
      nm = $signed({4'b0, mx[5:0], 8'b0} << 2) - $signed({2'b0, player_x}) +
           (r.dir_x[15] ? 18'sd1024 : 18'sd0);
      dsel = r.dir_x;
    end else begin
      nm = $signed({4'b0, my[5:0], 8'b0} << 2) - $signed({2'b0, player_y}) +
           (r.dir_y[15] ? 18'sd1024 : 18'sd0);
      dsel = r.dir_y;
    end
    nabs = nm[17] ? 17'(-nm) : nm[16:0];
    dabs = dsel[15] ? 16'(-dsel) : dsel;
  end

  // The operand select follows the start command in its own cycle.
  assign div_h = cmd.lh_start || (which && !cmd.wd_start);

  always_comb begin
    if (div_h) begin
      dv_num = 40'(ScreenRows) << 12;
      dv_den = wd;
    end else begin
      dv_num = {7'b0, nabs, 16'b0};
      dv_den = {8'b0, dabs};
    end
  end

  gdr_divider u_div (
    .clk(clk), .rst(rst),
    .start(cmd.wd_start || cmd.lh_start),
    .num(dv_num), .den(dv_den),
    .done(dv_done), .quot(dv_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.wd_start) which <= 1'b0;
    else if (cmd.lh_start) which <= 1'b1;
    if (dv_done) begin
      if (!which) begin
        wd <= (dv_den == 24'd0 || dv_q > {16'b0, WdMax}) ? WdMax : dv_q[23:0];
      end else begin
        lh <= (dv_den == 24'd0 || dv_q > 40'(LhMax)) ? LhMax : dv_q[11:0];
      end
    end
  end

  // Texture coordinate along the wall.
  logic signed [15:0] dalong;
  logic [15:0]        palong;
  logic [25:0]        along;
  assign dalong = side ? r.dir_x : r.dir_y;
  assign palong = side ? player_x : player_y;
  assign along = {palong[9:0], 16'b0} + prod[25:0];

  always_ff @(posedge clk) begin
    if (cmd.tex_mul) prod <= $signed({1'b0, wd}) * dalong;
  end

  always_comb begin
    tex = along[25:20];
    if ((side == 1'b0 && r.dir_x[15]) ||
        (side == 1'b1 && !r.dir_y[15] && r.dir_y != 16'sd0))
      tex = 6'(TexSize - 1) - tex;
  end

  // Draw rows.
  logic [12:0] ds, de;
  assign ds = 13'(ScreenRows / 2) - {2'b0, lh[11:1]};
  assign de = 13'(ScreenRows / 2) + {2'b0, lh[11:1]};

  // Result fields of a hit.
  always_comb begin
    fin = '0;
    fin.hit_side = side;
    fin.hit_col = mx[5:0];
    fin.hit_row = my[5:0];
    fin.wall_distance = wd;
    fin.slice_height = lh;
    fin.row_top = ds[12] ? 9'd0 : ds[8:0];
    fin.row_bottom = (de >= 13'(ScreenRows)) ? 9'(ScreenRows - 1) : de[8:0];
    fin.texture_col = tex;
  end

  // A cast starts out as leaving the map; a hit replaces the whole result.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res <= {1'b1, {($bits(res_t) - 1){1'b0}}};
    end else if (cmd.finish) begin
      res <= fin;
    end
  end
endmodule

### rtl/gdr_ctrl.sv
// Controller: sequences the map write, the DDA walk and the divisions.
module gdr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  gdr_pkg::sts_t sts,
  output gdr_pkg::cmd_t cmd,
  output logic          clr_en,
  output logic [11:0]   clr_addr
);
  import gdr_pkg::*;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_STEP  = 10'b0000000100,
    S_READ  = 10'b0000001000,
    S_CHECK = 10'b0000010000,
    S_WD    = 10'b0000100000,
    S_LH    = 10'b0001000000,
    S_TEX   = 10'b0010000000,
    S_FIN   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic   started;

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign clr_en = (state == S_CLEAR);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_CLEAR: if (clr_addr == 12'hFFF) state_next = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          if (sts.is_write) cmd.map_write = 1'b1;
          else begin
            cmd.load = 1'b1;
            state_next = S_STEP;
          end
        end
      end
      S_STEP: begin
        cmd.step = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        if (sts.outside) state_next = S_OUT;
        else state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.hit) begin
          cmd.wd_start = 1'b1;
          state_next = S_WD;
        end else state_next = S_STEP;
      end
      S_WD: begin
        if (sts.div_done) state_next = S_LH;
      end
      S_LH: begin
        if (!started) cmd.lh_start = 1'b1;
        else if (sts.div_done) state_next = S_TEX;
      end
      S_TEX: begin
        cmd.tex_mul = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      started <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + 12'd1;
      started <= (state_next == state) && (state == S_LH);
    end
  end
endmodule

### rtl/grid_dda_raycaster_top.sv
// Grid DDA ray caster with a 64x64 one-bit wall map; one request is worked on at a time.
// A map write is taken while idle and the next request may follow straight away.
// A cast steps through the map cell by cell; on a hit it runs the distance and height
// divisions one after the other, then forms the texture product and the result. One that
// leaves the map goes straight to the output. The result is held until taken.
// After reset a pass clears all 4096 map cells; configuration is taken throughout.
module grid_dda_raycaster_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  gdr_pkg::req_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output gdr_pkg::res_t  out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_data
);
  import gdr_pkg::*;

  logic [15:0] player_x, player_y;
  logic [6:0]  map_width, map_height;
  cmd_t        cmd;
  sts_t        sts;
  logic        clr_en;
  logic [11:0] clr_addr;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      player_x <= '0;
      player_y <= '0;
      map_width <= 7'd64;
      map_height <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgPlayerX: player_x <= cfg_data;
        CfgPlayerY: player_y <= cfg_data;
        CfgMapWidth: map_width <= cfg_data[6:0];
        CfgMapHeight: map_height <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  gdr_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .sts(sts), .cmd(cmd),
    .clr_en(clr_en), .clr_addr(clr_addr)
  );

  gdr_datapath u_dp (
    .clk(clk), .rst(rst),
    .req(in_data), .cmd(cmd),
    .player_x(player_x), .player_y(player_y),
    .map_width(map_width), .map_height(map_height),
    .clr_en(clr_en), .clr_addr(clr_addr),
    .sts(sts), .res(out_data)
  );
endmodule

### dv/tb_grid_dda_raycaster_top.sv
import gdr_pkg::*;

// Keeps a private copy of the wall map and the registers, works out the result
// of every accepted cast and compares it with what comes out of the block.
class raycast_scoreboard;
  bit          wall_map[MapDim*MapDim];
  bit [15:0]   player_x;
  bit [15:0]   player_y;
  bit [6:0]    map_width;
  bit [6:0]    map_height;
  res_t        pending_hits[$];
  int          errors;

  function new();
    foreach (wall_map[i]) wall_map[i] = 1'b0;
    player_x = '0;
    player_y = '0;
    map_width = 7'd64;
    map_height = 7'd64;
    errors = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [15:0] value);
    case (idx)
      CfgPlayerX:   player_x = value;
      CfgPlayerY:   player_y = value;
      CfgMapWidth:  map_width = value[6:0];
      CfgMapHeight: map_height = value[6:0];
      default: ;
    endcase
  endfunction

  function int outstanding();
    return pending_hits.size();
  endfunction

  // Walks the grid from the player cell and forms the wall slice.
  function res_t cast_ray(req_t r);
    longint dx, dy, mx, my, w, h, sx, sy, num, den, along, ds, de;
    longint unsigned delx, dely, sdx, sdy, fx, fy, wd, lh, tex, frac, quo;
    bit side;
    res_t o;
    o = '0;
    side = 1'b0;
    dx = r.dir_x;
    dy = r.dir_y;
    delx = r.delta_x;
    dely = r.delta_y;
    w = (map_width > MapDim) ? MapDim : map_width;
    h = (map_height > MapDim) ? MapDim : map_height;
    mx = player_x >> 10;
    my = player_y >> 10;
    fx = player_x & 16'h3FF;
    fy = player_y & 16'h3FF;
    if (dx < 0) begin
      sx = -1; sdx = (fx * delx) >> 10;
    end else begin
      sx = 1;  sdx = ((1024 - fx) * delx) >> 10;
    end
    if (dy < 0) begin
      sy = -1; sdy = (fy * dely) >> 10;
    end else begin
      sy = 1;  sdy = ((1024 - fy) * dely) >> 10;
    end
    // Ties in side distance step in y; the start cell is never tested.
    forever begin
      if (sdx < sdy) begin
        sdx += delx; mx += sx; side = 1'b0;
      end else begin
        sdy += dely; my += sy; side = 1'b1;
      end
      if (mx < 0 || my < 0 || mx >= w || my >= h) begin
        o.status = 1'b1;
        return o;
      end
      if (wall_map[int'(my) * MapDim + int'(mx)]) break;
    end
    if (!side) begin
      num = mx * 1024 - longint'(player_x) + ((sx < 0) ? 1024 : 0);
      den = dx;
    end else begin
      num = my * 1024 - longint'(player_y) + ((sy < 0) ? 1024 : 0);
      den = dy;
    end
    if (num < 0) num = -num;
    if (den < 0) den = -den;
    if (den == 0) begin
      wd = WdMax;
    end else begin
      quo = (longint'(num) << 16) / den;
      wd = (quo > WdMax) ? WdMax : quo;
    end
    if (wd == 0) begin
      lh = LhMax;
    end else begin
      lh = (longint'(ScreenRows) << 12) / wd;
      if (lh > LhMax) lh = LhMax;
    end
    ds = ScreenRows / 2 - longint'(lh / 2);
    if (ds < 0) ds = 0;
    de = ScreenRows / 2 + longint'(lh / 2);
    if (de >= ScreenRows) de = ScreenRows - 1;
    // Texture column from the fraction of the hit point along the wall.
    if (!side) along = (longint'(player_y) << 16) + longint'(wd) * dy;
    else       along = (longint'(player_x) << 16) + longint'(wd) * dx;
    frac = along & 64'h3FFFFFF;
    tex = (frac * TexSize) >> 26;
    if ((!side && dx < 0) || (side && dy > 0)) tex = TexSize - tex - 1;
    o.hit_side = side;
    o.hit_col = mx[5:0];
    o.hit_row = my[5:0];
    o.wall_distance = wd[23:0];
    o.slice_height = lh[11:0];
    o.row_top = ds[8:0];
    o.row_bottom = de[8:0];
    o.texture_col = tex[5:0];
    return o;
  endfunction

  function void note_request(req_t r);
    if (r.mode == ModeWrite) wall_map[int'(r.cell_y) * MapDim + int'(r.cell_x)] = r.cell_wall;
    else pending_hits.push_back(cast_ray(r));
  endfunction

  function void compare_field(string fname, longint unsigned e, longint unsigned a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, e, a);
      errors++;
    end
  endfunction

  function void check_result(res_t a);
    res_t e;
    if (pending_hits.size() == 0) begin
      $display("%0t: unexpected result, actual %h", $time, a);
      errors++;
      return;
    end
    e = pending_hits.pop_front();
    compare_field("status", e.status, a.status);
    compare_field("hit_side", e.hit_side, a.hit_side);
    compare_field("hit_col", e.hit_col, a.hit_col);
    compare_field("hit_row", e.hit_row, a.hit_row);
    compare_field("wall_distance", e.wall_distance, a.wall_distance);
    compare_field("slice_height", e.slice_height, a.slice_height);
    compare_field("row_top", e.row_top, a.row_top);
    compare_field("row_bottom", e.row_bottom, a.row_bottom);
    compare_field("texture_col", e.texture_col, a.texture_col);
  endfunction
endclass

module tb_grid_dda_raycaster_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  req_t        in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  res_t        out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CfgPlayerX;
  logic [15:0] cfg_data = '0;

  raycast_scoreboard sb = new();
  int n_sent = 0;
  int hold_off = 0;
  int idle_cycles = 0;

  grid_dda_raycaster_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Gap lengths: mostly none or short, now and then long.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Distance per cell crossing for a direction component, as a renderer would give.
  function automatic logic [23:0] crossing_step(logic signed [15:0] d);
    longint unsigned m, q;
    m = (d < 0) ? -longint'(d) : longint'(d);
    if (m == 0) return WdMax;
    q = (64'd1 << 26) / m;
    return (q > WdMax) ? WdMax : q[23:0];
  endfunction

  function automatic req_t cell_write(int x, int y, bit wall);
    req_t r;
    r = req_t'(($bits(req_t))'({$urandom, $urandom, $urandom}));
    r.mode = ModeWrite;
    r.cell_x = 6'(x);
    r.cell_y = 6'(y);
    r.cell_wall = wall;
    return r;
  endfunction

  function automatic req_t ray(logic signed [15:0] dx, logic signed [15:0] dy, bit raw);
    req_t r;
    r = req_t'(($bits(req_t))'({$urandom, $urandom, $urandom}));
    r.mode = ModeCast;
    r.dir_x = dx;
    r.dir_y = dy;
    if (!raw) begin
      r.delta_x = crossing_step(dx);
      r.delta_y = crossing_step(dy);
    end
    return r;
  endfunction

  task automatic send(req_t r);
    int g;
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
    n_sent++;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  // Lets every cast drain and any trailing map write settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Result side: random stall stretches, plus a long hold-off on request.
  initial begin
    int left;
    bit level;
    left = 0;
    level = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        out_stall <= 1'b1;
        hold_off--;
      end else begin
        if (left == 0) begin
          level = ($urandom_range(0, 2) == 0);
          left = level ? pick_gap() + 1 : $urandom_range(1, 60);
        end
        out_stall <= level;
        left--;
      end
    end
  end

  always @(posedge clk) begin
    if (out_valid && !out_stall) sb.check_result(out_data);
  end

  // Watchdog on cycles in which neither side moves a request or a result.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, sb.outstanding());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int w, h, nw, nc, phase, ew, eh;
    bit raw;
    logic signed [15:0] dx, dy;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: walls on the axes from the origin, extremes of direction.
    send(cell_write(5, 0, 1'b1));
    send(cell_write(0, 5, 1'b1));
    send(cell_write(63, 63, 1'b1));
    send(cell_write(63, 63, 1'b0));
    send(ray(16'sd16384, 16'sd0, 1'b0));
    send(ray(16'sd0, 16'sd16384, 1'b0));
    send(ray(-16'sd32768, 16'sd0, 1'b0));
    send(ray(16'sd0, 16'sd0, 1'b0));
    send(ray(16'sd32767, -16'sd32768, 1'b0));
    send(ray(16'sd16384, 16'sd16384, 1'b0));
    wait_idle();
    write_reg(CfgPlayerX, 16'hFFFF);
    write_reg(CfgPlayerY, 16'hFFFF);
    write_reg(CfgMapWidth, 16'd64);
    write_reg(CfgMapHeight, 16'd64);
    send(cell_write(62, 63, 1'b1));
    send(cell_write(63, 62, 1'b1));
    send(ray(-16'sd16384, 16'sd0, 1'b0));
    send(ray(16'sd0, -16'sd16384, 1'b0));
    send(ray(16'sd16384, 16'sd300, 1'b0));
    send(ray(-16'sd1, -16'sd1, 1'b1));
    wait_idle();
    // Empty map width: every cast leaves at once; oversized height acts as full.
    write_reg(CfgMapWidth, 16'd0);
    write_reg(CfgMapHeight, 16'd127);
    send(ray(-16'sd16384, -16'sd16384, 1'b0));
    wait_idle();
    write_reg(CfgMapWidth, 16'd127);
    write_reg(CfgMapHeight, 16'd0);
    send(ray(-16'sd16384, 16'sd100, 1'b0));

    // Random phases: new registers, a few map writes, then a run of casts.
    phase = 0;
    while (n_sent < 950) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0: begin w = $urandom_range(0, 1); h = $urandom_range(0, 127); end
        1: begin w = $urandom_range(65, 127); h = $urandom_range(1, 64); end
        2: begin w = 64; h = 64; end
        default: begin w = $urandom_range(4, 64); h = $urandom_range(4, 64); end
      endcase
      ew = (w > MapDim) ? MapDim : w;
      eh = (h > MapDim) ? MapDim : h;
      write_reg(CfgMapWidth, 16'(w));
      write_reg(CfgMapHeight, 16'(h));
      if (ew == 0 || eh == 0 || $urandom_range(0, 9) == 0) begin
        write_reg(CfgPlayerX, 16'($urandom));
        write_reg(CfgPlayerY, 16'($urandom));
      end else begin
        write_reg(CfgPlayerX,
                  16'(($urandom_range(0, ew - 1) << 10) | $urandom_range(0, 1023)));
        write_reg(CfgPlayerY,
                  16'(($urandom_range(0, eh - 1) << 10) | $urandom_range(0, 1023)));
      end
      nw = $urandom_range(4, 12);
      repeat (nw) begin
        if (ew > 0 && eh > 0 && $urandom_range(0, 4) != 0)
          send(cell_write($urandom_range(0, ew - 1), $urandom_range(0, eh - 1),
                          $urandom_range(0, 9) < 7));
        else
          send(cell_write($urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 1) == 1));
      end
      // One long hold-off on the result side while casts keep coming.
      if (phase == 5) hold_off = 3000;
      nc = $urandom_range(15, 35);
      repeat (nc) begin
        dx = 16'($urandom);
        dy = 16'($urandom);
        if ($urandom_range(0, 19) == 0) dx = 0;
        if ($urandom_range(0, 19) == 0) dy = 0;
        raw = ($urandom_range(0, 4) == 0);
        send(ray(dx, dy, raw));
      end
      phase++;
    end

    wait_idle();
    repeat (600) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
